// File: rtl/core/hwt_pkg.sv
package hwt_pkg;

  // Default sizes
  localparam int MAX_LOG2_LEN_DEF = 6;
  localparam int SAMPLE_BITS_DEF  = 24;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LOG2    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORWARD_LEVELS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MODE   = 2'd2;

  localparam logic [CFG_DATA_W-1:0] LENGTH_LOG2_RST    = 3'd6;
  localparam logic [CFG_DATA_W-1:0] FORWARD_LEVELS_RST = 3'd6;

  // Source of the sample memory write data
  typedef enum logic [1:0] {
    WSEL_SAMPLE,
    WSEL_SUM,
    WSEL_DIFF
  } wsel_e;

  // Controller to datapath command
  typedef struct packed {
    logic  ram_we;
    wsel_e wsel;
    logic  latch_x;
    logic  latch_y;
    logic  load_out;
    logic  out_end;
    logic  inverse;
  } hwt_cmd_t;

endpackage

// File: rtl/core/hwt_ram.sv
module hwt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/hwt_datapath.sv
module hwt_datapath import hwt_pkg::*; #(
  parameter int MAX_LOG2_LEN = MAX_LOG2_LEN_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hwt_cmd_t                      cmd_i,
  input  logic [MAX_LOG2_LEN-1:0]       addr_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  output logic                          out_free_o,
  output logic                          coeff_valid_o,
  input  logic                          coeff_ready_i,
  output logic signed [SAMPLE_BITS-1:0] coefficient_o,
  output logic [MAX_LOG2_LEN-1:0]       coeff_index_o,
  output logic                          block_end_o
);

  localparam int SB    = SAMPLE_BITS;
  localparam int DEPTH = 1 << MAX_LOG2_LEN;

  logic [SB-1:0]           rdata;
  logic [SB-1:0]           wdata;
  logic [SB-1:0]           x_q, y_q;
  logic [SB:0]             sum_w, dif_w;
  logic                    out_valid_q;
  logic [SB-1:0]           coeff_q;
  logic [MAX_LOG2_LEN-1:0] index_q;
  logic                    end_q;

  // Clip a grown value back into the signed sample range
  function automatic logic [SB-1:0] sat(input logic [SB:0] w);
    logic [SB-1:0] r;
    if (w[SB] != w[SB-1]) begin
      r = w[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
    end else begin
      r = w[SB-1:0];
    end
    return r;
  endfunction

  hwt_ram #(
    .WIDTH (SB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ram_we),
    .waddr_i (addr_i),
    .wdata_i (wdata),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  // Butterfly: sum uses the second operand straight off the read port
  assign sum_w = {x_q[SB-1], x_q} + {rdata[SB-1], rdata};
  assign dif_w = {x_q[SB-1], x_q} - {y_q[SB-1], y_q};

  always_comb begin
    case (cmd_i.wsel)
      WSEL_SAMPLE: wdata = sample_value_i;
      WSEL_SUM:    wdata = cmd_i.inverse ? sat(sum_w) : sum_w[SB:1];
      WSEL_DIFF:   wdata = cmd_i.inverse ? sat(dif_w) : dif_w[SB:1];
      default:     wdata = sample_value_i;
    endcase
  end

  // Operand registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_x) begin
      x_q <= rdata;
    end
    if (cmd_i.latch_y) begin
      y_q <= rdata;
    end
  end

  // Output register
  assign out_free_o = !out_valid_q || coeff_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (coeff_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      coeff_q <= rdata;
      index_q <= addr_i;
      end_q   <= cmd_i.out_end;
    end
  end

  assign coeff_valid_o = out_valid_q;
  assign coefficient_o = coeff_q;
  assign coeff_index_o = index_q;
  assign block_end_o   = end_q;

endmodule

// File: rtl/core/hwt_ctrl.sv
module hwt_ctrl import hwt_pkg::*; #(
  parameter int MAX_LOG2_LEN = MAX_LOG2_LEN_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                    sample_valid_i,
  output logic                    sample_ready_o,
  input  logic                    out_free_i,
  output hwt_cmd_t                cmd_o,
  output logic [MAX_LOG2_LEN-1:0] addr_o
);

  localparam int AW   = MAX_LOG2_LEN;
  localparam int CW   = AW + 1;
  localparam int LG_W = $clog2(MAX_LOG2_LEN + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_RDP,
    ST_BF_RDQ,
    ST_BF_WRP,
    ST_BF_WRQ,
    ST_EMIT_RD,
    ST_EMIT_WAIT
  } state_e;

  state_e                state_q, state_d;
  logic [CFG_DATA_W-1:0] len_q, len_d;
  logic [CFG_DATA_W-1:0] lvl_q, lvl_d;
  logic                  inv_q, inv_d;
  logic [CW-1:0]         load_cnt_q, load_cnt_d;
  logic [LG_W-1:0]       span_q, span_d;     // log2 of the pair distance
  logic [LG_W-1:0]       sweeps_q, sweeps_d; // sweeps still to run
  logic [AW-1:0]         k_q, k_d;           // pair or emit index

  logic [LG_W-1:0] lg_eff;
  logic [LG_W-1:0] levels;
  logic [LG_W-1:0] shamt;
  logic [AW-1:0]   n_mask;
  logic [AW-1:0]   k_last;
  logic [AW-1:0]   p_addr, q_addr;
  logic [CW-1:0]   n_len;
  logic [CW-1:0]   cnt_inc;
  logic            accept;

  // Effective block size and sweep count
  always_comb begin
    if (len_q == '0) begin
      lg_eff = LG_W'(1);
    end else if (len_q > CFG_DATA_W'(MAX_LOG2_LEN)) begin
      lg_eff = LG_W'(MAX_LOG2_LEN);
    end else begin
      lg_eff = LG_W'(len_q);
    end
    levels = (lvl_q > CFG_DATA_W'(lg_eff)) ? lg_eff : LG_W'(lvl_q);
  end

  // Pair addresses: p = k * 2^(span+1), q = p + 2^span
  assign n_mask  = ~({AW{1'b1}} << lg_eff);
  assign n_len   = CW'(1) << lg_eff;
  assign shamt   = span_q + LG_W'(1);
  assign k_last  = n_mask >> shamt;
  assign p_addr  = k_q << shamt;
  assign q_addr  = p_addr | (AW'(1) << span_q);
  assign cnt_inc = load_cnt_q + CW'(1);
  assign accept  = (state_q == ST_LOAD) && sample_valid_i;

  assign sample_ready_o = (state_q == ST_LOAD);

  // Command decode
  always_comb begin
    cmd_o          = '0;
    cmd_o.wsel     = WSEL_SAMPLE;
    cmd_o.inverse  = inv_q;
    cmd_o.out_end  = (k_q == n_mask);
    addr_o         = k_q;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.ram_we = sample_valid_i;
        addr_o       = load_cnt_q[AW-1:0];
      end
      ST_BF_RDP: begin
        addr_o = p_addr;
      end
      ST_BF_RDQ: begin
        cmd_o.latch_x = 1'b1;
        addr_o        = q_addr;
      end
      ST_BF_WRP: begin
        cmd_o.latch_y = 1'b1;
        cmd_o.ram_we  = 1'b1;
        cmd_o.wsel    = WSEL_SUM;
        addr_o        = p_addr;
      end
      ST_BF_WRQ: begin
        cmd_o.ram_we = 1'b1;
        cmd_o.wsel   = WSEL_DIFF;
        addr_o       = q_addr;
      end
      ST_EMIT_RD: begin
        addr_o = k_q;
      end
      ST_EMIT_WAIT: begin
        cmd_o.load_out = out_free_i;
        addr_o         = k_q;
      end
      default: begin
        addr_o = k_q;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d    = state_q;
    len_d      = len_q;
    lvl_d      = lvl_q;
    inv_d      = inv_q;
    load_cnt_d = load_cnt_q;
    span_d     = span_q;
    sweeps_d   = sweeps_q;
    k_d        = k_q;

    // Register writes
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LENGTH_LOG2:    len_d = cfg_wdata_i;
        CFG_FORWARD_LEVELS: lvl_d = cfg_wdata_i;
        CFG_INVERSE_MODE:   inv_d = cfg_wdata_i[0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_inc >= n_len) begin
            load_cnt_d = '0;
            k_d        = '0;
            if (inv_q) begin
              span_d   = lg_eff - LG_W'(1);
              sweeps_d = lg_eff;
              state_d  = ST_BF_RDP;
            end else begin
              span_d   = '0;
              sweeps_d = levels;
              state_d  = (levels == '0) ? ST_EMIT_RD : ST_BF_RDP;
            end
          end else begin
            load_cnt_d = cnt_inc;
          end
        end
      end
      ST_BF_RDP: state_d = ST_BF_RDQ;
      ST_BF_RDQ: state_d = ST_BF_WRP;
      ST_BF_WRP: state_d = ST_BF_WRQ;
      ST_BF_WRQ: begin
        if (k_q == k_last) begin
          k_d = '0;
          if (sweeps_q == LG_W'(1)) begin
            state_d = ST_EMIT_RD;
          end else begin
            sweeps_d = sweeps_q - LG_W'(1);
            span_d   = inv_q ? span_q - LG_W'(1) : span_q + LG_W'(1);
            state_d  = ST_BF_RDP;
          end
        end else begin
          k_d     = k_q + AW'(1);
          state_d = ST_BF_RDP;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_WAIT;
      ST_EMIT_WAIT: begin
        if (out_free_i) begin
          if (k_q == n_mask) begin
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      len_q      <= LENGTH_LOG2_RST;
      lvl_q      <= FORWARD_LEVELS_RST;
      inv_q      <= 1'b0;
      load_cnt_q <= '0;
      span_q     <= '0;
      sweeps_q   <= '0;
      k_q        <= '0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      lvl_q      <= lvl_d;
      inv_q      <= inv_d;
      load_cnt_q <= load_cnt_d;
      span_q     <= span_d;
      sweeps_q   <= sweeps_d;
      k_q        <= k_d;
    end
  end

endmodule

// File: rtl/core/haar_wavelet_block_transform.sv
// Haar wavelet block transform, in place, fixed point.
//
// Samples come in on the sample request channel (valid/ready), one per
// request, into a 2^length_log2 entry store. The request that completes the
// block starts the transform: forward_levels halving sweeps, or with
// inverse_mode set all levels of saturating sum/difference. Then every
// coefficient goes out on the coefficient channel in index order, with
// block_end on the last one. Registers are written through the cfg port.
//
// Each butterfly reads both operands, then writes both results, on the
// single read / single write sample memory, so a full 64-entry transform
// over all levels runs 63 butterflies. Each coefficient then passes a
// memory read and the output register. Reset returns to loading with an
// empty block and the default registers; the memory is not cleared. A
// stalled receiver holds the output register and pauses the emit; the next
// block loads as soon as the last coefficient sits in the output register.
module haar_wavelet_block_transform import hwt_pkg::*; #(
  parameter int MAX_LOG2_LEN = MAX_LOG2_LEN_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata_i,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  output logic                          coeff_valid_o,
  input  logic                          coeff_ready_i,
  output logic signed [SAMPLE_BITS-1:0] coefficient_o,
  output logic [MAX_LOG2_LEN-1:0]       coeff_index_o,
  output logic                          block_end_o
);

  hwt_cmd_t                cmd;
  logic [MAX_LOG2_LEN-1:0] addr;
  logic                    out_free;

  hwt_ctrl #(
    .MAX_LOG2_LEN (MAX_LOG2_LEN)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_valid_i (sample_valid_i),
    .sample_ready_o (sample_ready_o),
    .out_free_i     (out_free),
    .cmd_o          (cmd),
    .addr_o         (addr)
  );

  hwt_datapath #(
    .MAX_LOG2_LEN (MAX_LOG2_LEN),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .addr_i         (addr),
    .sample_value_i (sample_value_i),
    .out_free_o     (out_free),
    .coeff_valid_o  (coeff_valid_o),
    .coeff_ready_i  (coeff_ready_i),
    .coefficient_o  (coefficient_o),
    .coeff_index_o  (coeff_index_o),
    .block_end_o    (block_end_o)
  );

endmodule

// File: rtl/core/hwt_checker.sv
module hwt_checker import hwt_pkg::*; #(
  parameter int MAX_LOG2_LEN = MAX_LOG2_LEN_DEF,
  parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          sample_ready_o,
  input logic                          coeff_valid_o,
  input logic                          coeff_ready_i,
  input logic signed [SAMPLE_BITS-1:0] coefficient_o,
  input logic [MAX_LOG2_LEN-1:0]       coeff_index_o,
  input logic                          block_end_o
);

  // No result shows in the cycle after a reset edge
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !coeff_valid_o)
    else $error("coefficient valid after reset");

  // A stalled coefficient holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coeff_valid_o && !coeff_ready_i |=> coeff_valid_o && $stable(coefficient_o)
      && $stable(coeff_index_o) && $stable(block_end_o))
    else $error("stalled coefficient changed");

  // No sample is taken while a block is still going out
  a_no_load_mid_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coeff_valid_o && !block_end_o |-> !sample_ready_o)
    else $error("sample ready before block emitted");

  // The last index of a block is 2^n - 1
  a_end_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    coeff_valid_o && block_end_o
      |-> (coeff_index_o & MAX_LOG2_LEN'(coeff_index_o + 1'b1)) == '0)
    else $error("block end on a bad index");

endmodule

bind haar_wavelet_block_transform hwt_checker #(
  .MAX_LOG2_LEN (MAX_LOG2_LEN),
  .SAMPLE_BITS  (SAMPLE_BITS)
) u_hwt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_ready_o (sample_ready_o),
  .coeff_valid_o  (coeff_valid_o),
  .coeff_ready_i  (coeff_ready_i),
  .coefficient_o  (coefficient_o),
  .coeff_index_o  (coeff_index_o),
  .block_end_o    (block_end_o)
);
